// ----- rtl/core/mcg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator package
// Shared constants, action codes and the command and status structures that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
package mcg_pkg;

  localparam int COORD_BITS_DEF = 10;

  localparam logic ACT_START = 1'b0;
  localparam logic ACT_STEP  = 1'b1;

  localparam int PIX_IDX_W = 4;
  localparam logic [PIX_IDX_W-1:0] HALF_IDX = 4'd7;
  localparam logic [PIX_IDX_W-1:0] LAST_IDX = 4'd15;

  localparam int DEC_INIT    = 3;
  localparam int DEC_STEP_X  = 6;
  localparam int DEC_STEP_XY = 10;

  typedef struct packed {
    logic                 load_start;
    logic                 clear_active;
    logic                 emit;
    logic [PIX_IDX_W-1:0] idx;
  } mcg_cmd_t;

  typedef struct packed {
    logic active;
    logic x_lt_y;
    logic out_busy;
  } mcg_status_t;

endpackage

// ----- rtl/core/mcg_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator command channel
// Valid/ready channel carrying start and step items.
// ----------------------------------------------------------------------------
interface mcg_in_if #(
  parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [COORD_BITS-2:0] radius;

  modport source (output valid, output action, output center_x, output center_y,
                  output radius, input ready);
  modport sink (input valid, input action, input center_x, input center_y,
                input radius, output ready);
endinterface

// ----- rtl/core/mcg_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator pixel channel
// Valid/ready channel carrying one plotted pixel per item.
// ----------------------------------------------------------------------------
interface mcg_out_if #(
  parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS+1:0] pixel_x;
  logic signed [COORD_BITS+1:0] pixel_y;
  logic                         last;
  logic                         done_res;

  modport source (output valid, output pixel_x, output pixel_y, output last,
                  output done_res, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last,
                input done_res, output ready);
endinterface

// ----- rtl/core/mcg_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator controller
// Accepts command items and sequences the sixteen pixel emissions of a step.
// ----------------------------------------------------------------------------
module mcg_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_action,
  output logic                in_ready,
  input  mcg_pkg::mcg_status_t status,
  output mcg_pkg::mcg_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t                        state;
  state_t                        state_next;
  logic [mcg_pkg::PIX_IDX_W-1:0] idx;
  logic [mcg_pkg::PIX_IDX_W-1:0] idx_next;
  logic                          accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    cmd.load_start   = 1'b0;
    cmd.clear_active = 1'b0;
    cmd.emit         = 1'b0;
    cmd.idx          = idx;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == mcg_pkg::ACT_START) begin
            cmd.load_start = 1'b1;
          end else if (status.active) begin
            if (status.x_lt_y) begin
              state_next = ST_RUN;
              idx_next   = '0;
            end else begin
              cmd.clear_active = 1'b1;
            end
          end
        end
      end
      ST_RUN: begin
        if (!status.out_busy) begin
          cmd.emit = 1'b1;
          if (idx == mcg_pkg::LAST_IDX) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

endmodule

// ----- rtl/core/mcg_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator datapath
// Holds the centre, octant point and decision value, forms the symmetric
// pixels and drives the registered pixel output.
// ----------------------------------------------------------------------------
module mcg_dp #(
  parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [COORD_BITS-1:0] center_x,
  input  logic [COORD_BITS-1:0] center_y,
  input  logic [COORD_BITS-2:0] radius,
  input  mcg_pkg::mcg_cmd_t     cmd,
  output mcg_pkg::mcg_status_t  status,
  mcg_out_if.source             pix
);

  localparam int PIX_W = COORD_BITS + 2;
  localparam int DEC_W = COORD_BITS + 4;

  logic [COORD_BITS-1:0]   center_col;
  logic [COORD_BITS-1:0]   center_row;
  logic [COORD_BITS-1:0]   octant_x;
  logic [COORD_BITS-1:0]   octant_y;
  logic signed [DEC_W-1:0] decision;
  logic                    active;

  logic                    out_valid;
  logic [PIX_W-1:0]        out_x;
  logic [PIX_W-1:0]        out_y;
  logic                    out_last;
  logic                    out_done;

  logic [COORD_BITS-1:0]   x_inc;
  logic [COORD_BITS-1:0]   y_dec;
  logic signed [DEC_W-1:0] dec_plus_x;
  logic signed [DEC_W-1:0] dec_plus_xy;
  logic signed [DEC_W-1:0] dec_init;
  logic                    x_lt_y;
  logic                    is_last;
  logic                    is_half;
  logic [COORD_BITS-1:0]   sel_a;
  logic [COORD_BITS-1:0]   sel_b;
  logic [PIX_W-1:0]        off_a;
  logic [PIX_W-1:0]        off_b;
  logic [PIX_W-1:0]        pix_x_calc;
  logic [PIX_W-1:0]        pix_y_calc;

  assign x_lt_y  = (octant_x < octant_y);
  assign is_last = (cmd.idx == mcg_pkg::LAST_IDX);
  assign is_half = (cmd.idx == mcg_pkg::HALF_IDX);

  assign x_inc       = octant_x + 1'b1;
  assign y_dec       = octant_y - 1'b1;
  assign dec_plus_x  = decision + (DEC_W'(x_inc) <<< 2) + DEC_W'(mcg_pkg::DEC_STEP_X);
  assign dec_plus_xy = decision + ((DEC_W'(x_inc) - DEC_W'(y_dec)) <<< 2)
                       + DEC_W'(mcg_pkg::DEC_STEP_XY);
  assign dec_init    = DEC_W'(mcg_pkg::DEC_INIT) - (DEC_W'(radius) <<< 1);

  assign sel_a      = cmd.idx[2] ? octant_y : octant_x;
  assign sel_b      = cmd.idx[2] ? octant_x : octant_y;
  assign off_a      = cmd.idx[0] ? (PIX_W'(0) - PIX_W'(sel_a)) : PIX_W'(sel_a);
  assign off_b      = cmd.idx[1] ? (PIX_W'(0) - PIX_W'(sel_b)) : PIX_W'(sel_b);
  assign pix_x_calc = PIX_W'(center_col) + off_a;
  assign pix_y_calc = PIX_W'(center_row) + off_b;

  assign status.active   = active;
  assign status.x_lt_y   = x_lt_y;
  assign status.out_busy = out_valid && !pix.ready;

  assign pix.valid    = out_valid;
  assign pix.pixel_x  = $signed(out_x);
  assign pix.pixel_y  = $signed(out_y);
  assign pix.last     = out_last;
  assign pix.done_res = out_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col <= '0;
      center_row <= '0;
      octant_x   <= '0;
      octant_y   <= '0;
      decision   <= '0;
    end else if (cmd.load_start) begin
      center_col <= center_x;
      center_row <= center_y;
      octant_x   <= '0;
      octant_y   <= COORD_BITS'(radius);
      decision   <= dec_init;
    end else if (cmd.emit && is_half) begin
      octant_x <= x_inc;
      if (decision < 0) begin
        decision <= dec_plus_x;
      end else begin
        octant_y <= y_dec;
        decision <= dec_plus_xy;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (cmd.load_start) begin
      active <= 1'b1;
    end else if (cmd.clear_active) begin
      active <= 1'b0;
    end else if (cmd.emit && is_last && !x_lt_y) begin
      active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_x    <= pix_x_calc;
      out_y    <= pix_y_calc;
      out_last <= is_last;
      out_done <= is_last && !x_lt_y;
    end
  end

endmodule

// ----- rtl/core/midpoint_circle_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator
// Rasterises circles by the midpoint method with eight-way symmetry.
// ----------------------------------------------------------------------------
// A start item loads the centre and radius and produces no pixels. A step
// item on an active circle whose octant point has x below y produces
// sixteen pixel items, the eight symmetric pixels of the current octant
// point and then those of the next, one per cycle from a single output
// register while the pixel channel does not stall, and the next command
// item is taken once the sixteenth pixel sits in the output register.
// The last pixel of a step is marked, and done_res marks it as well when
// the circle is complete; further steps then produce nothing until the
// next start.
module midpoint_circle_generator #(
  parameter int COORD_BITS = mcg_pkg::COORD_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  mcg_in_if.sink     cmd,
  mcg_out_if.source  pix
);

  mcg_pkg::mcg_cmd_t    dp_cmd;
  mcg_pkg::mcg_status_t dp_status;
  logic                 in_ready;

  assign cmd.ready = in_ready;

  mcg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_action (cmd.action),
    .in_ready  (in_ready),
    .status    (dp_status),
    .cmd       (dp_cmd)
  );

  mcg_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .center_x (cmd.center_x),
    .center_y (cmd.center_y),
    .radius   (cmd.radius),
    .cmd      (dp_cmd),
    .status   (dp_status),
    .pix      (pix)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Midpoint circle generator testbench
// Drives start and step commands into the rasteriser and checks every pixel
// against an in-bench model of the midpoint circle walk. A table of directed
// commands is followed by random circles, abandoned circles and noise, with
// random idling on both channels and a long stall on the pixel channel.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CB = mcg_pkg::COORD_BITS_DEF;
  localparam int PW = CB + 2;
  localparam int RAND_CMDS = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic          act;
    logic [CB-1:0] cx;
    logic [CB-1:0] cy;
    logic [CB-2:0] rad;
  } circle_cmd_t;

  typedef struct packed {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic          last;
    logic          done;
  } pixel_t;

  // Rows marked silent are known to give no pixels at all.
  typedef struct packed {
    circle_cmd_t cmd;
    logic        silent;
  } script_row_t;

  localparam script_row_t SCRIPT [25] = '{
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b1},
    '{'{mcg_pkg::ACT_START, 10'd0,    10'd0,    9'd0},   1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd1023, 10'd1023, 9'd511}, 1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b1},
    '{'{mcg_pkg::ACT_START, 10'd0,    10'd0,    9'd1},   1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b1},
    '{'{mcg_pkg::ACT_START, 10'd1023, 10'd1023, 9'd511}, 1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd341,  10'd682,  9'd170}, 1'b0},
    '{'{mcg_pkg::ACT_START, 10'd0,    10'd1023, 9'd511}, 1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd1023, 10'd0,    9'd511}, 1'b0},
    '{'{mcg_pkg::ACT_START, 10'd1023, 10'd0,    9'd2},   1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b1},
    '{'{mcg_pkg::ACT_START, 10'd341,  10'd682,  9'd341}, 1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd682,  10'd341,  9'd170}, 1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_START, 10'd512,  10'd512,  9'd5},   1'b1},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0},
    '{'{mcg_pkg::ACT_STEP,  10'd0,    10'd0,    9'd0},   1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  mcg_in_if  #(.COORD_BITS(CB)) cmd_if ();
  mcg_out_if #(.COORD_BITS(CB)) pix_if ();

  midpoint_circle_generator #(.COORD_BITS(CB)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .pix (pix_if)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [CB-1:0] ctr_col;
  logic [CB-1:0] ctr_row;
  logic [CB-1:0] oct_x;
  logic [CB-1:0] oct_y;
  int            decision;
  bit            circle_on;

  pixel_t due_pixels [$];
  pixel_t want_pix;

  int  mismatches = 0;
  int  cmds_taken = 0;
  int  pixels_checked = 0;
  int  circles_started = 0;
  int  circles_closed = 0;
  int  idle_cycles = 0;
  bit  send_quiet = 1'b0;
  bit  recv_quiet = 1'b0;
  bit  hold_req = 1'b0;

  function automatic int draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic void push_octet(bit record, bit close, bit fin);
    logic [PW-1:0] cx;
    logic [PW-1:0] cy;
    logic [PW-1:0] p;
    logic [PW-1:0] q;
    pixel_t run [8];
    if (!record) return;
    cx = {2'b00, ctr_col};
    cy = {2'b00, ctr_row};
    p = {2'b00, oct_x};
    q = {2'b00, oct_y};
    run[0] = '{cx + p, cy + q, 1'b0, 1'b0};
    run[1] = '{cx - p, cy + q, 1'b0, 1'b0};
    run[2] = '{cx + p, cy - q, 1'b0, 1'b0};
    run[3] = '{cx - p, cy - q, 1'b0, 1'b0};
    run[4] = '{cx + q, cy + p, 1'b0, 1'b0};
    run[5] = '{cx - q, cy + p, 1'b0, 1'b0};
    run[6] = '{cx + q, cy - p, 1'b0, 1'b0};
    run[7] = '{cx - q, cy - p, close, fin};
    foreach (run[i]) due_pixels.push_back(run[i]);
  endfunction

  // Advances the circle state by one command and, when record is set, queues the pixels it draws.
  // Returns 0 for a step that the block ignores.
  function automatic bit rasterise_cmd(circle_cmd_t c, bit record);
    bit fin;
    if (c.act == mcg_pkg::ACT_START) begin
      ctr_col = c.cx;
      ctr_row = c.cy;
      oct_x = '0;
      oct_y = {1'b0, c.rad};
      decision = mcg_pkg::DEC_INIT - 2 * int'(c.rad);
      circle_on = 1'b1;
      circles_started++;
      return 1'b1;
    end
    if (!circle_on) return 1'b0;
    if (oct_x >= oct_y) begin
      circle_on = 1'b0;
      return 1'b1;
    end
    push_octet(record, 1'b0, 1'b0);
    oct_x = oct_x + 1'b1;
    if (decision < 0) begin
      decision = decision + 4 * int'(oct_x) + mcg_pkg::DEC_STEP_X;
    end else begin
      oct_y = oct_y - 1'b1;
      decision = decision + 4 * (int'(oct_x) - int'(oct_y)) + mcg_pkg::DEC_STEP_XY;
    end
    fin = (oct_x >= oct_y);
    push_octet(record, 1'b1, fin);
    if (fin) begin
      circle_on = 1'b0;
      circles_closed++;
    end
    return 1'b1;
  endfunction

  // The valid line is left high after a handshake, so that a following item
  // with no gap needs no second assignment in the same step.
  task automatic send_cmd(input circle_cmd_t c, input bit silent, output bit took);
    int gap;
    gap = draw_wait(send_quiet);
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid    <= 1'b1;
    cmd_if.action   <= c.act;
    cmd_if.center_x <= c.cx;
    cmd_if.center_y <= c.cy;
    cmd_if.radius   <= c.rad;
    do @(posedge clk); while (!cmd_if.ready);
    cmds_taken++;
    took = rasterise_cmd(c, !silent);
  endtask

  task automatic drain_pixels();
    cmd_if.valid <= 1'b0;
    do @(posedge clk); while (due_pixels.size() != 0);
  endtask

  function automatic circle_cmd_t random_cmd(logic act);
    circle_cmd_t c;
    c.act = act;
    c.cx = CB'($urandom_range(0, (1 << CB) - 1));
    c.cy = CB'($urandom_range(0, (1 << CB) - 1));
    c.rad = (CB - 1)'($urandom_range(0, (1 << (CB - 1)) - 1));
    return c;
  endfunction

  initial begin
    cmd_if.valid    <= 1'b0;
    cmd_if.action   <= mcg_pkg::ACT_STEP;
    cmd_if.center_x <= '0;
    cmd_if.center_y <= '0;
    cmd_if.radius   <= '0;
    ctr_col = '0;
    ctr_row = '0;
    oct_x = '0;
    oct_y = '0;
    decision = 0;
    circle_on = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin : stimulus
    circle_cmd_t c;
    bit          took;
    int          counted;
    int          budget;
    int          steps;
    int          pick;
    bit          stressed;
    counted = 0;
    stressed = 1'b0;
    while (rst !== 1'b0 || cmd_if.valid !== 1'b0) @(posedge clk);
    foreach (SCRIPT[i]) send_cmd(SCRIPT[i].cmd, SCRIPT[i].silent, took);
    drain_pixels();

    while (counted < RAND_CMDS) begin
      if ($urandom_range(0, 9) == 0) begin
        send_cmd(random_cmd(1'($urandom_range(0, 1))), 1'b0, took);
        counted += took;
      end else begin
        c = random_cmd(mcg_pkg::ACT_START);
        pick = $urandom_range(0, 9);
        if (pick < 6) c.rad = (CB - 1)'($urandom_range(0, 12));
        else if (pick < 9) c.rad = (CB - 1)'($urandom_range(13, 80));
        budget = (c.rad > 64) ? $urandom_range(1, 40) : 1000;
        if ($urandom_range(0, 3) == 0) budget = $urandom_range(1, 8);
        send_cmd(c, 1'b0, took);
        counted += took;
        steps = 0;
        while (circle_on && steps < budget && counted < RAND_CMDS) begin
          send_cmd(random_cmd(mcg_pkg::ACT_STEP), 1'b0, took);
          counted += took;
          steps++;
        end
        if ($urandom_range(0, 2) == 0) begin
          send_cmd(random_cmd(mcg_pkg::ACT_STEP), 1'b0, took);
          counted += took;
        end
      end
      if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
      if ($urandom_range(0, 19) == 0) drain_pixels();
      if (!stressed && counted >= 200) begin
        // A large circle with the pixel channel held off, so that the block
        // backs up and refuses further steps until the stall ends.
        stressed = 1'b1;
        c = random_cmd(mcg_pkg::ACT_START);
        c.rad = (CB - 1)'($urandom_range(400, 511));
        send_cmd(c, 1'b0, took);
        send_cmd(random_cmd(mcg_pkg::ACT_STEP), 1'b0, took);
        hold_req = 1'b1;
        repeat (4) send_cmd(random_cmd(mcg_pkg::ACT_STEP), 1'b0, took);
        counted += 6;
        drain_pixels();
      end
    end

    drain_pixels();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Commands taken: %0d, circles started: %0d, circles completed: %0d.",
             cmds_taken, circles_started, circles_closed);
    $display("Pixels checked: %0d, mismatches: %0d.", pixels_checked, mismatches);
    if (mismatches == 0) begin
      $display("[midpoint_circle_generator] OK");
    end else begin
      $display("[midpoint_circle_generator] ERROR");
    end
    $finish;
  end

  initial begin : receiver
    int stall;
    pix_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pix_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = draw_wait(recv_quiet);
      if (stall > 0) begin
        pix_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_if.ready <= 1'b1;
      do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
      if ($urandom_range(0, 49) == 0) recv_quiet = !recv_quiet;
    end
  end

  always @(posedge clk) begin
    if (!rst && pix_if.valid && pix_if.ready) begin
      pixels_checked++;
      if (due_pixels.size() == 0) begin
        $display("%0t unexpected pixel: expected none, got (%0d, %0d) last %b done %b",
                 $time, pix_if.pixel_x, pix_if.pixel_y, pix_if.last, pix_if.done_res);
        mismatches++;
      end else begin
        want_pix = due_pixels.pop_front();
        if (pix_if.pixel_x !== want_pix.px) begin
          $display("%0t pixel_x mismatch: expected %0d, got %0d",
                   $time, $signed(want_pix.px), pix_if.pixel_x);
          mismatches++;
        end
        if (pix_if.pixel_y !== want_pix.py) begin
          $display("%0t pixel_y mismatch: expected %0d, got %0d",
                   $time, $signed(want_pix.py), pix_if.pixel_y);
          mismatches++;
        end
        if (pix_if.last !== want_pix.last) begin
          $display("%0t last mismatch: expected %b, got %b",
                   $time, want_pix.last, pix_if.last);
          mismatches++;
        end
        if (pix_if.done_res !== want_pix.done) begin
          $display("%0t done_res mismatch: expected %b, got %b",
                   $time, want_pix.done, pix_if.done_res);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t no item accepted for %0d cycles, %0d pixels still due",
               $time, idle_cycles, due_pixels.size());
      $display("[midpoint_circle_generator] ERROR");
      $finish;
    end
  end

endmodule
